[src/image_header_dimension_sniffer_macros.svh]
// assertion macros used by the checker file
`ifndef IMAGE_HEADER_DIMENSION_SNIFFER_MACROS_SVH
`define IMAGE_HEADER_DIMENSION_SNIFFER_MACROS_SVH

// same-cycle implication, disabled while reset is active
`define IHDS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is active
`define IHDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/ihds_pkg.sv]
package ihds_pkg;

    localparam int DATA_W  = 8;
    localparam int TLEN_W  = 24;
    localparam int DIM_W   = 31;
    localparam int HOLD_W  = 32;
    localparam int SEG_W   = 16;

    // byte codes
    localparam logic [7:0] BYTE_FF   = 8'hFF;
    localparam logic [7:0] BYTE_SOI  = 8'hD8;
    localparam logic [7:0] BYTE_EOI  = 8'hD9;
    localparam logic [7:0] BYTE_RST0 = 8'hD0;
    localparam logic [7:0] BYTE_RST7 = 8'hD7;
    localparam logic [7:0] BYTE_SOF0 = 8'hC0;
    localparam logic [7:0] BYTE_SOFF = 8'hCF;
    localparam logic [7:0] BYTE_DHT  = 8'hC4;
    localparam logic [7:0] BYTE_JPG  = 8'hC8;
    localparam logic [7:0] BYTE_DAC  = 8'hCC;

    // input transfer payload
    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic [TLEN_W-1:0] total_length;
    } t_in;

    // result transfer payload
    typedef struct packed {
        logic [DIM_W-1:0] image_width;
        logic [DIM_W-1:0] image_height;
    } t_out;

    typedef enum logic [2:0] {
        PH_SIG,
        PH_SCAN,
        PH_MARKER,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_SOF,
        PH_DONE
    } t_phase;

    // png signature byte at offset 0..7
    function automatic logic [7:0] png_sig(input logic [2:0] idx);
        logic [7:0] v;
        unique case (idx)
            3'd0: v = 8'h89;
            3'd1: v = 8'h50;
            3'd2: v = 8'h4E;
            3'd3: v = 8'h47;
            3'd4: v = 8'h0D;
            3'd5: v = 8'h0A;
            3'd6: v = 8'h1A;
            3'd7: v = 8'h0A;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // start-of-frame marker test
    function automatic logic is_sof(input logic [7:0] m);
        return (m >= BYTE_SOF0) && (m <= BYTE_SOFF) &&
               (m != BYTE_DHT) && (m != BYTE_JPG) && (m != BYTE_DAC);
    endfunction

endpackage

[src/ihds_core.sv]
module ihds_core #(
    parameter int LENGTH_BITS = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  ihds_pkg::t_in i_in,
    output logic          o_last,
    output ihds_pkg::t_out o_result
);
    import ihds_pkg::*;

    localparam int LB  = LENGTH_BITS;
    localparam int LB1 = LENGTH_BITS + 1;

    t_phase           r_phase, n_phase;
    logic [LB-1:0]    r_pos, n_pos;
    logic             r_png_ok, n_png_ok;
    logic             r_jpeg_ok, n_jpeg_ok;
    logic [7:0]       r_marker, n_marker;
    logic [SEG_W-1:0] r_seglen, n_seglen;
    logic [LB-1:0]    r_nmp, n_nmp;
    logic [HOLD_W-1:0] r_width, n_width;
    logic [HOLD_W-1:0] r_height, n_height;

    logic [31:0]      len32;
    logic [LB-1:0]    len;
    logic [7:0]       b;
    logic [LB1-1:0]   pos_x;
    logic [LB1-1:0]   len_x;

    assign len32 = {{(32-TLEN_W){1'b0}}, i_in.total_length};
    assign len   = len32[LB-1:0];
    assign b     = i_in.data_byte;
    assign pos_x = {1'b0, r_pos};
    assign len_x = {1'b0, len};

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SIG;
            r_pos     <= '0;
            r_png_ok  <= 1'b1;
            r_jpeg_ok <= 1'b1;
            r_marker  <= '0;
            r_seglen  <= '0;
            r_nmp     <= LB'(2);
            r_width   <= '0;
            r_height  <= '0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_png_ok  <= n_png_ok;
            r_jpeg_ok <= n_jpeg_ok;
            r_marker  <= n_marker;
            r_seglen  <= n_seglen;
            r_nmp     <= n_nmp;
            r_width   <= n_width;
            r_height  <= n_height;
        end
    end

    // per-byte parse step
    always_comb begin
        logic [LB1-1:0]   p1;
        logic [LB1-1:0]   p3;
        logic [LB1-1:0]   p9;
        logic [SEG_W-1:0] sl;
        logic [LB1-1:0]   seg_end;
        logic [LB-1:0]    sof_off;
        logic             last;

        p1      = pos_x + LB1'(1);
        p3      = pos_x + LB1'(3);
        p9      = pos_x + LB1'(9);
        sl      = r_seglen | {8'h00, b};
        seg_end = {1'b0, r_nmp} + LB1'(sl);
        sof_off = r_pos - r_nmp;
        last    = !(p1 < len_x);

        n_phase   = r_phase;
        n_png_ok  = r_png_ok;
        n_jpeg_ok = r_jpeg_ok;
        n_marker  = r_marker;
        n_seglen  = r_seglen;
        n_nmp     = r_nmp;
        n_width   = r_width;
        n_height  = r_height;

        // signature checks
        if (r_pos < LB'(8) && b != png_sig(r_pos[2:0])) begin
            n_png_ok = 1'b0;
        end
        if (r_pos == LB'(0) && b != BYTE_FF) begin
            n_jpeg_ok = 1'b0;
        end
        if (r_pos == LB'(1) && b != BYTE_SOI) begin
            n_jpeg_ok = 1'b0;
        end

        // png dimension words, or one step of the jpeg marker walk
        if (n_png_ok) begin
            if (r_pos >= LB'(16) && r_pos < LB'(20)) begin
                n_width = {r_width[HOLD_W-9:0], b};
            end else if (r_pos >= LB'(20) && r_pos < LB'(24)) begin
                n_height = {r_height[HOLD_W-9:0], b};
            end
        end else if (n_jpeg_ok && r_pos >= LB'(2)) begin
            unique case (r_phase)
                PH_SCAN: begin
                    if (r_pos == r_nmp) begin
                        if (!(p9 < len_x)) begin
                            n_phase = PH_DONE;
                        end else if (b == BYTE_FF) begin
                            n_phase = PH_MARKER;
                        end else begin
                            n_nmp = p1[LB-1:0];
                        end
                    end
                end
                PH_MARKER: begin
                    n_nmp = p1[LB-1:0];
                    if (b == BYTE_SOI || b == BYTE_EOI ||
                        (b >= BYTE_RST0 && b <= BYTE_RST7)) begin
                        n_phase = PH_SCAN;
                    end else if (p3 > len_x) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_marker = b;
                        n_phase  = PH_LEN_HI;
                    end
                end
                PH_LEN_HI: begin
                    n_seglen = {b, 8'h00};
                    n_phase  = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_seglen = sl;
                    if (sl < SEG_W'(2) || seg_end > len_x) begin
                        n_phase = PH_DONE;
                    end else if (is_sof(r_marker)) begin
                        n_phase = (sl >= SEG_W'(7)) ? PH_SOF : PH_DONE;
                    end else begin
                        n_nmp   = seg_end[LB-1:0];
                        n_phase = PH_SCAN;
                    end
                end
                PH_SOF: begin
                    unique case (sof_off)
                        LB'(3): n_height = {16'h0000, b, 8'h00};
                        LB'(4): n_height = r_height | {24'h000000, b};
                        LB'(5): n_width  = {16'h0000, b, 8'h00};
                        LB'(6): begin
                            n_width = r_width | {24'h000000, b};
                            if (n_width == '0 || r_height == '0) begin
                                n_width  = '0;
                                n_height = '0;
                            end
                            n_phase = PH_DONE;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end

        // second byte decides whether the walk starts
        if (r_pos == LB'(1)) begin
            n_phase = n_jpeg_ok ? PH_SCAN : PH_DONE;
        end

        // result on the last byte
        o_last   = last;
        o_result = '0;
        if (len >= LB'(2)) begin
            if (n_png_ok) begin
                if (len >= LB'(24) && n_width != '0 && n_height != '0 &&
                    !n_width[HOLD_W-1] && !n_height[HOLD_W-1]) begin
                    o_result.image_width  = n_width[DIM_W-1:0];
                    o_result.image_height = n_height[DIM_W-1:0];
                end
            end else if (n_jpeg_ok) begin
                o_result.image_width  = n_width[DIM_W-1:0];
                o_result.image_height = n_height[DIM_W-1:0];
            end
        end

        // advance, or return to the start state for the next file
        if (last) begin
            n_pos     = '0;
            n_phase   = PH_SIG;
            n_png_ok  = 1'b1;
            n_jpeg_ok = 1'b1;
            n_marker  = '0;
            n_seglen  = '0;
            n_nmp     = LB'(2);
            n_width   = '0;
            n_height  = '0;
        end else begin
            n_pos = p1[LB-1:0];
        end
    end

endmodule

[src/image_header_dimension_sniffer.sv]
// channel   direction  valid       ready        payload
// input     in         i_in_valid  o_in_ready   i_in_data  (data_byte, total_length)
// result    out        o_out_valid i_out_ready  o_out_data (image_width, image_height)
//
// one byte is taken per cycle while o_in_ready is high; the parse state updates in the cycle of the transfer
// the result of a file appears in the cycle after its last byte, through one output register
// o_in_ready drops only while a result waits and i_out_ready is low
// reset is synchronous, active low, and returns the parser to the start of a file
module image_header_dimension_sniffer #(
    parameter int LENGTH_BITS = 24
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  ihds_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output ihds_pkg::t_out o_out_data
);
    import ihds_pkg::*;

    logic   in_xfer;
    logic   last;
    t_out   result;
    logic   r_out_valid;
    t_out   r_out_data;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_xfer    = i_in_valid && o_in_ready;

    // header parser
    ihds_core #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_xfer),
        .i_in     (i_in_data),
        .o_last   (last),
        .o_result (result)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer && last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && last) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

[src/ihds_checker.sv]
`include "image_header_dimension_sniffer_macros.svh"

module ihds_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input ihds_pkg::t_in  i_in_data,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input ihds_pkg::t_out o_out_data
);
    import ihds_pkg::*;

    // a waiting result stays until its transfer
    `IHDS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid, "result dropped")

    // a stalled result keeps its value
    `IHDS_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_out_data), "result changed while stalled")

    // input is only held back by a waiting result
    `IHDS_ASSERT_NOW(a_in_ready, i_clk, i_rst_n, !o_out_valid || i_out_ready, o_in_ready, "input stalled without cause")

endmodule

bind image_header_dimension_sniffer ihds_checker u_ihds_checker (.*);

[tb/tb.sv]
module tb;
    import ihds_pkg::*;

    localparam int WATCHDOG_LIMIT = 500;
    localparam int RANDOM_BYTES   = 1400;
    localparam int CALM_TAIL      = 200;
    localparam int DRAIN_CYCLES   = 8;
    localparam logic [63:0] PNG_SIGNATURE = 64'h8950_4E47_0D0A_1A0A;

    // smallest jpeg whose frame header is found: soi, sof0 with length 7,
    // height and width at their extreme, one byte so the walk may start
    localparam logic [7:0] TINY_JPEG [12] = '{
        BYTE_FF, BYTE_SOI, BYTE_FF, BYTE_SOF0, 8'h00, 8'h07,
        8'h08, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00
    };

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_ready;
    t_in  in_data   = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out out_data;

    bit          idling       = 1'b0;
    int unsigned stall_left   = 0;
    int unsigned quiet_cycles = 0;
    int unsigned files_built  = 0;
    t_in         byte_stream[$];
    logic [7:0]  file_body[$];

    function automatic logic [7:0] magic_byte(logic [2:0] idx);
        return PNG_SIGNATURE[8*(7-idx) +: 8];
    endfunction

    // c0..cf except the three with low bits 00 above c0
    function automatic bit is_frame_marker(logic [7:0] m);
        return m[7:4] == 4'hC && !(m[1:0] == 2'b00 && m[3:2] != 2'b00);
    endfunction

    function automatic bit is_lone_marker(logic [7:0] m);
        return m >= BYTE_RST0 && m <= BYTE_EOI;
    endfunction

    // expected image sizes, predicted byte by byte
    class dims_board;
        logic [31:0] pos;
        logic [31:0] next_pos;
        t_phase      phase;
        bit          png_ok;
        bit          jpg_ok;
        logic [7:0]  marker;
        logic [15:0] seg_len;
        logic [31:0] w_hold;
        logic [31:0] h_hold;
        t_out        expected_dims[$];
        int unsigned faults;
        int unsigned checked;
        int unsigned sized;

        function new();
            restart();
        endfunction

        function void restart();
            pos      = '0;
            next_pos = 32'd2;
            phase    = PH_SIG;
            png_ok   = 1'b1;
            jpg_ok   = 1'b1;
            marker   = '0;
            seg_len  = '0;
            w_hold   = '0;
            h_hold   = '0;
        endfunction

        function void note_byte(t_in item);
            logic [7:0]  b;
            logic [31:0] p;
            logic [31:0] n;
            t_out        dims;
            b = item.data_byte;
            n = 32'(item.total_length);
            p = pos;
            if (p < 8 && b != magic_byte(p[2:0])) png_ok = 1'b0;
            if (p == 0 && b != BYTE_FF) jpg_ok = 1'b0;
            if (p == 1 && b != BYTE_SOI) jpg_ok = 1'b0;

            if (png_ok) begin
                // big-endian width then height right after the ihdr tag
                if (p >= 16 && p < 20) w_hold = {w_hold[23:0], b};
                else if (p >= 20 && p < 24) h_hold = {h_hold[23:0], b};
            end else if (jpg_ok && p >= 2) begin
                // jpeg marker walk
                case (phase)
                    PH_SCAN: begin
                        if (p == next_pos) begin
                            if (!(p + 9 < n)) phase = PH_DONE;
                            else if (b == BYTE_FF) phase = PH_MARKER;
                            else next_pos = p + 1;
                        end
                    end
                    PH_MARKER: begin
                        next_pos = p + 1;
                        if (is_lone_marker(b)) begin
                            phase = PH_SCAN;
                        end else if (p + 3 > n) begin
                            phase = PH_DONE;
                        end else begin
                            marker = b;
                            phase  = PH_LEN_HI;
                        end
                    end
                    PH_LEN_HI: begin
                        seg_len = {b, 8'h00};
                        phase   = PH_LEN_LO;
                    end
                    PH_LEN_LO: begin
                        seg_len = {seg_len[15:8], b};
                        if (seg_len < 16'd2 || next_pos + 32'(seg_len) > n) begin
                            phase = PH_DONE;
                        end else if (is_frame_marker(marker)) begin
                            if (seg_len >= 16'd7) phase = PH_SOF;
                            else phase = PH_DONE;
                        end else begin
                            next_pos = next_pos + 32'(seg_len);
                            phase    = PH_SCAN;
                        end
                    end
                    PH_SOF: begin
                        // offsets from the length field: height at 3-4, width at 5-6
                        case (p - next_pos)
                            32'd3: h_hold = {16'd0, b, 8'd0};
                            32'd4: h_hold = h_hold | 32'(b);
                            32'd5: w_hold = {16'd0, b, 8'd0};
                            32'd6: begin
                                w_hold = w_hold | 32'(b);
                                if (w_hold == 0 || h_hold == 0) begin
                                    w_hold = '0;
                                    h_hold = '0;
                                end
                                phase = PH_DONE;
                            end
                            default: ;
                        endcase
                    end
                    default: ;
                endcase
            end
            if (p == 1) begin
                if (jpg_ok) phase = PH_SCAN;
                else phase = PH_DONE;
            end

            if (p + 1 < n) begin
                pos = p + 1;
                return;
            end

            // last byte of the file: report and start over
            dims = '0;
            if (n >= 2) begin
                if (png_ok) begin
                    if (n >= 24 && w_hold != 0 && h_hold != 0 && !w_hold[31] && !h_hold[31]) begin
                        dims.image_width  = w_hold[30:0];
                        dims.image_height = h_hold[30:0];
                    end
                end else if (jpg_ok) begin
                    dims.image_width  = w_hold[30:0];
                    dims.image_height = h_hold[30:0];
                end
            end
            expected_dims.push_back(dims);
            restart();
        endfunction

        function void check_dims(t_out got);
            t_out want;
            if (expected_dims.size() == 0) begin
                $display("%0t: result with none expected: width %0d height %0d",
                         $time, got.image_width, got.image_height);
                faults++;
                return;
            end
            want = expected_dims.pop_front();
            checked++;
            if (want.image_width != 0 && want.image_height != 0) sized++;
            if (got.image_width !== want.image_width) begin
                $display("%0t: image_width expected %0d actual %0d",
                         $time, want.image_width, got.image_width);
                faults++;
            end
            if (got.image_height !== want.image_height) begin
                $display("%0t: image_height expected %0d actual %0d",
                         $time, want.image_height, got.image_height);
                faults++;
            end
        endfunction
    endclass

    dims_board board = new();

    image_header_dimension_sniffer uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always #2 clk = ~clk;

    // result side: random stall bursts while idling is on
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready  <= 1'b1;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_ready  <= (stall_left == 1);
        end else if (idling && $urandom_range(0, 11) == 0) begin
            stall_left <= $urandom_range(1, 18);
            out_ready  <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // transfer monitor and watchdog
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) board.note_byte(in_data);
            if (out_valid && out_ready) board.check_dims(out_data);
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
                $display("FAIL");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    function automatic void add_byte(logic [7:0] b, logic [23:0] n);
        t_in item;
        item.data_byte    = b;
        item.total_length = n;
        byte_stream.push_back(item);
    endfunction

    // image dimension with zero, negative, tiny and maximum values mixed in
    function automatic logic [31:0] pick_dim();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return $urandom | 32'h8000_0000;
            2: return 32'($urandom_range(1, 255));
            3: return 32'h7FFF_FFFF;
            default: return $urandom >> $urandom_range(0, 30);
        endcase
    endfunction

    task automatic send_byte(t_in item);
        if (idling && $urandom_range(0, 9) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
    endtask

    initial begin
        logic [31:0] w;
        logic [31:0] h;
        logic [15:0] seg;
        logic [7:0]  m;
        int unsigned cut;
        int unsigned len_field;
        int unsigned choice;
        bit          vary;

        // short files, a minimal jpeg, files cut short by the length field
        add_byte(8'h00, 24'd0);
        add_byte(BYTE_FF, 24'd1);
        add_byte(BYTE_FF, 24'd2);
        add_byte(BYTE_SOI, 24'd2);
        for (int k = 0; k < 12; k++) add_byte(TINY_JPEG[k], 24'd12);
        add_byte(magic_byte(3'd0), 24'hFF_FFFF);
        add_byte(magic_byte(3'd1), 24'd2);
        add_byte(BYTE_FF, 24'd9);
        add_byte(8'h00, 24'd1);
        files_built = 6;

        // random files, mostly well formed png and jpeg headers
        while (byte_stream.size() < RANDOM_BYTES) begin
            file_body.delete();
            choice = $urandom_range(0, 19);
            if (choice < 7) begin
                // png: signature, chunk length and tag, width, height
                for (int k = 0; k < 8; k++) file_body.push_back(magic_byte(3'(k)));
                repeat (8) file_body.push_back(8'($urandom));
                w = pick_dim();
                h = pick_dim();
                for (int k = 3; k >= 0; k--) file_body.push_back(w[8*k +: 8]);
                for (int k = 3; k >= 0; k--) file_body.push_back(h[8*k +: 8]);
                repeat ($urandom_range(0, 6)) file_body.push_back(8'($urandom));
            end else if (choice < 16) begin
                // jpeg: soi, a few fill bytes, lone markers and segments, then a frame header
                file_body.push_back(BYTE_FF);
                file_body.push_back(BYTE_SOI);
                repeat ($urandom_range(0, 3)) begin
                    case ($urandom_range(0, 3))
                        0: repeat ($urandom_range(1, 3))
                            file_body.push_back(8'($urandom_range(0, 254)));
                        1: begin
                            file_body.push_back(BYTE_FF);
                            file_body.push_back(8'($urandom_range(BYTE_RST0, BYTE_EOI)));
                        end
                        default: begin
                            m = 8'($urandom);
                            if (is_lone_marker(m) || is_frame_marker(m))
                                m = {4'hC, 2'($urandom_range(1, 3)), 2'b00};
                            seg = 16'($urandom_range(2, 7));
                            file_body.push_back(BYTE_FF);
                            file_body.push_back(m);
                            file_body.push_back(seg[15:8]);
                            file_body.push_back(seg[7:0]);
                            repeat (seg - 2) file_body.push_back(8'($urandom));
                        end
                    endcase
                end
                do m = {4'hC, 4'($urandom)}; while (!is_frame_marker(m));
                choice = $urandom_range(0, 9);
                if (choice == 0) seg = 16'($urandom_range(0, 1));
                else if (choice == 1) seg = 16'($urandom_range(2, 6));
                else if (choice == 2) seg = 16'($urandom_range(12, 65535));
                else seg = 16'($urandom_range(7, 11));
                w = pick_dim();
                h = pick_dim();
                file_body.push_back(BYTE_FF);
                file_body.push_back(m);
                file_body.push_back(seg[15:8]);
                file_body.push_back(seg[7:0]);
                file_body.push_back(8'($urandom));
                file_body.push_back(h[15:8]);
                file_body.push_back(h[7:0]);
                file_body.push_back(w[15:8]);
                file_body.push_back(w[7:0]);
                if (seg > 7 && seg < 12) repeat (seg - 7) file_body.push_back(8'($urandom));
                repeat ($urandom_range(0, 12)) file_body.push_back(8'($urandom));
            end else begin
                // noise, sometimes opening like one of the known formats
                case ($urandom_range(0, 2))
                    0: file_body.push_back(magic_byte(3'd0));
                    1: file_body.push_back(BYTE_FF);
                    default: file_body.push_back(8'($urandom));
                endcase
                repeat ($urandom_range(0, 29)) file_body.push_back(8'($urandom));
            end

            // occasional damage: one byte overwritten or the tail cut off
            if ($urandom_range(0, 7) == 0)
                file_body[$urandom_range(0, file_body.size() - 1)] = 8'($urandom);
            if ($urandom_range(0, 9) == 0) begin
                cut = $urandom_range(1, file_body.size());
                while (file_body.size() > cut) void'(file_body.pop_back());
            end

            // length field, sometimes different on each byte but never ending early
            vary = ($urandom_range(0, 4) == 0);
            for (int k = 0; k + 1 < file_body.size(); k++) begin
                if (!vary) begin
                    len_field = file_body.size();
                end else begin
                    case ($urandom_range(0, 2))
                        0: len_field = file_body.size();
                        1: len_field = $urandom_range(k + 2, 24'hFF_FFFF);
                        default: len_field = k + 2;
                    endcase
                end
                add_byte(file_body[k], 24'(len_field));
            end
            len_field = file_body.size();
            if (vary && $urandom_range(0, 1) == 1) len_field = $urandom_range(0, file_body.size());
            add_byte(file_body[file_body.size() - 1], 24'(len_field));
            files_built++;
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (int k = 0; k < byte_stream.size(); k++) begin
            idling = (k + CALM_TAIL < byte_stream.size()) && ((k / 160) % 4 != 3);
            send_byte(byte_stream[k]);
        end
        in_valid <= 1'b0;

        while (board.expected_dims.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("streamed %0d bytes in %0d png, jpeg and malformed files",
                 byte_stream.size(), files_built);
        $display("checked %0d results, %0d of them with a size found",
                 board.checked, board.sized);
        if (board.faults == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
